### rtl/core/rsav_pkg.sv
// ----------------------------------------------------------------------------
// rsav_pkg
// Shared types, codes and constant tables of the RSA e=3 PKCS#1 v1.5 verifier.
// ----------------------------------------------------------------------------
`default_nettype none

package rsav_pkg;

  localparam int KEY_WORDS    = 64;
  localparam int IDX_W        = $clog2(KEY_WORDS);
  localparam int WORD_W       = 32;
  localparam int DIGEST_WORDS = 5;
  localparam int DIG_W        = $clog2(DIGEST_WORDS);
  localparam int DIGEST_BYTES = DIGEST_WORDS * 4;
  localparam int TOTAL_BYTES  = KEY_WORDS * 4;
  localparam int PAD_WORDS    = KEY_WORDS - DIGEST_WORDS;
  localparam int PREFIX_BYTES = 15;
  localparam int SEP_BYTE     = TOTAL_BYTES - DIGEST_BYTES - PREFIX_BYTES - 1;
  localparam int NUM_MEM      = 5;

  localparam int ACTION_W    = 3;
  localparam int WIDX_W      = 6;
  localparam int SIG_BYTES_W = 10;
  localparam int STATUS_W    = 3;
  localparam int KWC_W       = 8;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MINV = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KWC  = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_MOD    = 3'd0,
    ACT_R2     = 3'd1,
    ACT_SIG    = 3'd2,
    ACT_DIGEST = 3'd3,
    ACT_VERIFY = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_KEY_LEN = 3'd1,
    ST_SIG_LEN = 3'd2,
    ST_PAD     = 3'd3,
    ST_DIGEST  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    MEM_MOD = 3'd0,
    MEM_R2  = 3'd1,
    MEM_SIG = 3'd2,
    MEM_WP1 = 3'd3,
    MEM_WP2 = 3'd4
  } mem_e;

  typedef struct packed {
    logic  en;
    mem_e  id;
    idx_t  addr;
    word_t data;
  } mem_wr_t;

  typedef struct packed {
    logic    valid;
    status_e status;
  } eng_res_t;

  localparam logic [7:0] PREFIX [PREFIX_BYTES] = '{
    8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h0e, 8'h03,
    8'h02, 8'h1a, 8'h05, 8'h00, 8'h04, 8'h14
  };

  // expected byte k of the padded block, k = 0 most significant
  function automatic logic [7:0] pad_byte(input int k);
    logic [7:0] b;
    b = 8'h00;
    if (k == 0) begin
      b = 8'h00;
    end else if (k == 1) begin
      b = 8'h01;
    end else if (k < SEP_BYTE) begin
      b = 8'hff;
    end else if (k == SEP_BYTE) begin
      b = 8'h00;
    end else if (k - SEP_BYTE - 1 < PREFIX_BYTES) begin
      b = PREFIX[k - SEP_BYTE - 1];
    end
    return b;
  endfunction

  // expected word w counted from the top of the result
  function automatic word_t pad_word(input idx_t w);
    word_t res;
    res = '0;
    for (int b = 0; b < 4; b++) begin
      res[WORD_W-1-8*b -: 8] = pad_byte(int'(w) * 4 + b);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/rsav_if.sv
// ----------------------------------------------------------------------------
// rsav_if
// Request, result and register-write channels of the verifier.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsav_item_if;
  logic                                valid;
  logic                                ready;
  logic [rsav_pkg::ACTION_W-1:0]       action;
  logic [rsav_pkg::WIDX_W-1:0]         word_index;
  logic [rsav_pkg::WORD_W-1:0]         data_word;
  logic [rsav_pkg::SIG_BYTES_W-1:0]    signature_bytes;
  modport source (output valid, action, word_index, data_word, signature_bytes, input ready);
  modport sink   (input valid, action, word_index, data_word, signature_bytes, output ready);
endinterface

interface rsav_result_if;
  logic                          valid;
  logic                          ready;
  logic [rsav_pkg::STATUS_W-1:0] status;
  logic                          verified;
  modport source (output valid, status, verified, input ready);
  modport sink   (input valid, status, verified, output ready);
endinterface

interface rsav_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rsav_pkg::CFG_IDX_W-1:0] index;
  logic [rsav_pkg::WORD_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/rsa_e3_pkcs1_sha1_verify_core.sv
// ----------------------------------------------------------------------------
// rsa_e3_pkcs1_sha1_verify_core
// RSA public exponent 3 signature check, PKCS#1 v1.5 padding, SHA-1 digest.
// ----------------------------------------------------------------------------
//  port      | dir | carries
//  ----------+-----+--------------------------------------------------
//  item_i    | in  | load word into a store, or verify request
//  result_o  | out | status and verified flag, one per verify request
//  cfg_i     | in  | montgomery_inverse (0), key_word_count (1)
//
//  A verify runs the shared word multiply loop, which reads one scratch word
//  per step. A length failure goes straight to the result without running
//  it. item_i is held off while a verify runs; a finished status waits in
//  the output register without holding off loads. Reset clears control,
//  config and output registers; stores, digest words and datapath
//  registers are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_e3_pkcs1_sha1_verify_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  rsav_item_if.sink     item_i,
  rsav_result_if.source result_o,
  rsav_cfg_if.sink      cfg_i
);

  rsav_pkg::word_t                              minv_q, minv_d;
  logic [rsav_pkg::KWC_W-1:0]                   kwc_q, kwc_d;
  rsav_pkg::word_t [rsav_pkg::DIGEST_WORDS-1:0] dig_q;

  logic                                         busy;
  logic                                         item_acc;
  logic                                         start;
  rsav_pkg::mem_wr_t                            load_wr, eng_wr, mem_wr;
  rsav_pkg::idx_t  [rsav_pkg::NUM_MEM-1:0]      rd_addr;
  rsav_pkg::word_t [rsav_pkg::NUM_MEM-1:0]      rd_data;
  rsav_pkg::eng_res_t                           eng_res;
  logic                                         res_ready;

  logic                                         out_valid_q;
  rsav_pkg::status_e                            out_status_q;

  logic                                         idx_ok;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    minv_d = minv_q;
    kwc_d  = kwc_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rsav_pkg::CFG_MINV: minv_d = cfg_i.data;
        rsav_pkg::CFG_KWC:  kwc_d  = cfg_i.data[rsav_pkg::KWC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minv_q <= '0;
      kwc_q  <= rsav_pkg::KWC_W'(rsav_pkg::KEY_WORDS);
    end else begin
      minv_q <= minv_d;
      kwc_q  <= kwc_d;
    end
  end

  assign item_i.ready = !busy;
  assign item_acc     = item_i.valid && item_i.ready;
  assign start        = item_acc && (item_i.action == rsav_pkg::ACT_VERIFY);
  assign idx_ok       = (int'(item_i.word_index) < rsav_pkg::KEY_WORDS);

  always_comb begin
    load_wr      = '0;
    load_wr.addr = rsav_pkg::idx_t'(item_i.word_index);
    load_wr.data = item_i.data_word;
    unique case (item_i.action)
      rsav_pkg::ACT_MOD: begin
        load_wr.id = rsav_pkg::MEM_MOD;
        load_wr.en = item_acc && idx_ok;
      end
      rsav_pkg::ACT_R2: begin
        load_wr.id = rsav_pkg::MEM_R2;
        load_wr.en = item_acc && idx_ok;
      end
      rsav_pkg::ACT_SIG: begin
        load_wr.id = rsav_pkg::MEM_SIG;
        load_wr.en = item_acc && idx_ok;
      end
      default: begin
        load_wr.id = rsav_pkg::MEM_MOD;
        load_wr.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (item_acc && (item_i.action == rsav_pkg::ACT_DIGEST)
        && (int'(item_i.word_index) < rsav_pkg::DIGEST_WORDS)) begin
      dig_q[rsav_pkg::DIG_W'(item_i.word_index)] <= item_i.data_word;
    end
  end

  // loads only land while the engine is idle
  assign mem_wr = eng_wr.en ? eng_wr : load_wr;

  rsav_store u_store (
    .clk_i     (clk_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (mem_wr)
  );

  rsav_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .sig_bytes_i (item_i.signature_bytes),
    .key_count_i (kwc_q),
    .minv_i      (minv_q),
    .digest_i    (dig_q),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_o        (eng_wr),
    .res_o       (eng_res),
    .res_ready_i (res_ready),
    .busy_o      (busy)
  );

  assign res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_status_q <= rsav_pkg::ST_OK;
    end else if (eng_res.valid && res_ready) begin
      out_valid_q  <= 1'b1;
      out_status_q <= eng_res.status;
    end else if (result_o.ready) begin
      out_valid_q  <= 1'b0;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.status   = out_status_q;
  assign result_o.verified = (out_status_q == rsav_pkg::ST_OK);

endmodule

`default_nettype wire

### rtl/core/rsav_store.sv
// ----------------------------------------------------------------------------
// rsav_store
// Modulus, R^2, signature and two scratch word memories, one read and one
// write port each, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rsav_store (
  input  logic                                            clk_i,
  input  rsav_pkg::idx_t  [rsav_pkg::NUM_MEM-1:0]         rd_addr_i,
  output rsav_pkg::word_t [rsav_pkg::NUM_MEM-1:0]         rd_data_o,
  input  rsav_pkg::mem_wr_t                               wr_i
);

  for (genvar g = 0; g < rsav_pkg::NUM_MEM; g++) begin : g_mem
    rsav_pkg::word_t ram [rsav_pkg::KEY_WORDS];
    rsav_pkg::word_t rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_i.id == rsav_pkg::mem_e'(3'(g)))) begin
        ram[wr_i.addr] <= wr_i.data;
      end
      rd_q <= ram[rd_addr_i[g]];
    end

    assign rd_data_o[g] = rd_q;
  end

endmodule

`default_nettype wire

### rtl/core/rsav_engine.sv
// ----------------------------------------------------------------------------
// rsav_engine
// Sequencer and word datapath: three Montgomery products, partial and final
// subtracts of n, and the padding / digest comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module rsav_engine (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  logic [rsav_pkg::SIG_BYTES_W-1:0]              sig_bytes_i,
  input  logic [rsav_pkg::KWC_W-1:0]                    key_count_i,
  input  rsav_pkg::word_t                               minv_i,
  input  rsav_pkg::word_t [rsav_pkg::DIGEST_WORDS-1:0]  digest_i,
  output rsav_pkg::idx_t  [rsav_pkg::NUM_MEM-1:0]       rd_addr_o,
  input  rsav_pkg::word_t [rsav_pkg::NUM_MEM-1:0]       rd_data_i,
  output rsav_pkg::mem_wr_t                             wr_o,
  output rsav_pkg::eng_res_t                            res_o,
  input  logic                                          res_ready_i,
  output logic                                          busy_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_XRD   = 4'd1;
  localparam logic [3:0] S_XWT   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_ADDP  = 4'd5;
  localparam logic [3:0] S_QMUL  = 4'd6;
  localparam logic [3:0] S_NMUL  = 4'd7;
  localparam logic [3:0] S_ADDR  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_NXT   = 4'd10;
  localparam logic [3:0] S_SUBRD = 4'd11;
  localparam logic [3:0] S_SUBLP = 4'd12;
  localparam logic [3:0] S_CMPRD = 4'd13;
  localparam logic [3:0] S_CMPLP = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  localparam logic [1:0] MM_FIRST  = 2'd0;
  localparam logic [1:0] MM_SECOND = 2'd1;
  localparam logic [1:0] MM_THIRD  = 2'd2;

  localparam rsav_pkg::idx_t LAST = rsav_pkg::idx_t'(rsav_pkg::KEY_WORDS - 1);

  logic [3:0]        state_q, state_d;
  logic [1:0]        mm_q, mm_d;
  rsav_pkg::idx_t    i_q, i_d, j_q, j_d, k_q, k_d;
  logic              borrow_q, borrow_d;
  logic              fin_q, fin_d;
  rsav_pkg::mem_e    src_q, src_d, tgt_q, tgt_d, sel_q, sel_d;
  rsav_pkg::status_e status_q, status_d;

  rsav_pkg::word_t   m_q, m_d, q_q, q_d, acc_q, acc_d, nw_q, nw_d;
  logic [63:0]       pa_q, pa_d, pb_q, pb_d, p_q, p_d, r_q, r_d;

  rsav_pkg::mem_e    x_mem, y_mem, d_mem;
  logic [32:0]       top_sum;
  logic [32:0]       diff;
  rsav_pkg::word_t   expect_w;
  logic [rsav_pkg::DIG_W-1:0] dsel;

  // operand roles of the current product
  always_comb begin
    unique case (mm_q)
      MM_FIRST: begin
        x_mem = rsav_pkg::MEM_SIG;
        y_mem = rsav_pkg::MEM_R2;
        d_mem = rsav_pkg::MEM_WP1;
      end
      MM_SECOND: begin
        x_mem = rsav_pkg::MEM_WP1;
        y_mem = rsav_pkg::MEM_WP1;
        d_mem = rsav_pkg::MEM_WP2;
      end
      default: begin
        x_mem = rsav_pkg::MEM_WP2;
        y_mem = rsav_pkg::MEM_SIG;
        d_mem = rsav_pkg::MEM_WP1;
      end
    endcase
  end

  assign top_sum  = {1'b0, p_q[63:32]} + {1'b0, r_q[63:32]};
  assign diff     = {1'b0, rd_data_i[src_q]} - {1'b0, rd_data_i[rsav_pkg::MEM_MOD]}
                    - {32'd0, borrow_q};
  assign dsel     = rsav_pkg::DIG_W'(k_q - rsav_pkg::idx_t'(rsav_pkg::PAD_WORDS));
  assign expect_w = (k_q < rsav_pkg::idx_t'(rsav_pkg::PAD_WORDS)) ? rsav_pkg::pad_word(k_q)
                                                                  : digest_i[dsel];

  always_comb begin
    state_d  = state_q;
    mm_d     = mm_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    borrow_d = borrow_q;
    fin_d    = fin_q;
    src_d    = src_q;
    tgt_d    = tgt_q;
    sel_d    = sel_q;
    status_d = status_q;
    m_d      = m_q;
    q_d      = q_q;
    acc_d    = acc_q;
    nw_d     = nw_q;
    pa_d     = pa_q;
    pb_d     = pb_q;
    p_d      = p_q;
    r_d      = r_q;
    rd_addr_o = '0;
    wr_o      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (key_count_i != rsav_pkg::KWC_W'(rsav_pkg::KEY_WORDS)) begin
            status_d = rsav_pkg::ST_KEY_LEN;
            state_d  = S_DONE;
          end else if (sig_bytes_i != rsav_pkg::SIG_BYTES_W'(rsav_pkg::TOTAL_BYTES)) begin
            status_d = rsav_pkg::ST_SIG_LEN;
            state_d  = S_DONE;
          end else begin
            mm_d    = MM_FIRST;
            i_d     = '0;
            state_d = S_XRD;
          end
        end
      end
      S_XRD: begin
        rd_addr_o[x_mem] = i_q;
        state_d          = S_XWT;
      end
      S_XWT: begin
        m_d     = rd_data_i[x_mem];
        j_d     = '0;
        state_d = S_RD;
      end
      S_RD: begin
        rd_addr_o[y_mem]             = j_q;
        rd_addr_o[d_mem]             = j_q;
        rd_addr_o[rsav_pkg::MEM_MOD] = j_q;
        state_d                      = S_MUL;
      end
      S_MUL: begin
        pa_d    = m_q * rd_data_i[y_mem];
        pb_d    = q_q * rd_data_i[rsav_pkg::MEM_MOD];
        nw_d    = rd_data_i[rsav_pkg::MEM_MOD];
        // scratch is treated as zero on the first outer step
        acc_d   = (i_q == '0) ? '0 : rd_data_i[d_mem];
        state_d = S_ADDP;
      end
      S_ADDP: begin
        p_d     = pa_q + {32'd0, acc_q} + ((j_q == '0) ? 64'd0 : {32'd0, p_q[63:32]});
        state_d = (j_q == '0) ? S_QMUL : S_ADDR;
      end
      S_QMUL: begin
        q_d     = p_q[31:0] * minv_i;
        state_d = S_NMUL;
      end
      S_NMUL: begin
        pb_d    = q_q * nw_q;
        state_d = S_ADDR;
      end
      S_ADDR: begin
        r_d = pb_q + {32'd0, p_q[31:0]} + ((j_q == '0) ? 64'd0 : {32'd0, r_q[63:32]});
        if (j_q != '0) begin
          wr_o.en   = 1'b1;
          wr_o.id   = d_mem;
          wr_o.addr = j_q - rsav_pkg::idx_t'(1);
          wr_o.data = r_d[31:0];
        end
        if (j_q == LAST) begin
          state_d = S_FIN;
        end else begin
          j_d     = j_q + rsav_pkg::idx_t'(1);
          state_d = S_RD;
        end
      end
      S_FIN: begin
        wr_o.en   = 1'b1;
        wr_o.id   = d_mem;
        wr_o.addr = LAST;
        wr_o.data = top_sum[31:0];
        if (top_sum[32]) begin
          src_d   = d_mem;
          tgt_d   = d_mem;
          fin_d   = 1'b0;
          state_d = S_SUBRD;
        end else begin
          state_d = S_NXT;
        end
      end
      S_NXT: begin
        if (i_q == LAST) begin
          i_d = '0;
          if (mm_q == MM_THIRD) begin
            // final reduction lands in the other scratch store
            src_d   = rsav_pkg::MEM_WP1;
            tgt_d   = rsav_pkg::MEM_WP2;
            fin_d   = 1'b1;
            state_d = S_SUBRD;
          end else begin
            mm_d    = mm_q + 2'd1;
            state_d = S_XRD;
          end
        end else begin
          i_d     = i_q + rsav_pkg::idx_t'(1);
          state_d = S_XRD;
        end
      end
      S_SUBRD: begin
        rd_addr_o[src_q]             = '0;
        rd_addr_o[rsav_pkg::MEM_MOD] = '0;
        k_d                          = '0;
        borrow_d                     = 1'b0;
        state_d                      = S_SUBLP;
      end
      S_SUBLP: begin
        wr_o.en                      = 1'b1;
        wr_o.id                      = tgt_q;
        wr_o.addr                    = k_q;
        wr_o.data                    = diff[31:0];
        borrow_d                     = diff[32];
        rd_addr_o[src_q]             = k_q + rsav_pkg::idx_t'(1);
        rd_addr_o[rsav_pkg::MEM_MOD] = k_q + rsav_pkg::idx_t'(1);
        if (k_q == LAST) begin
          if (fin_q) begin
            // borrow out means x < n: keep the unreduced copy
            sel_d   = diff[32] ? rsav_pkg::MEM_WP1 : rsav_pkg::MEM_WP2;
            state_d = S_CMPRD;
          end else begin
            state_d = S_NXT;
          end
        end else begin
          k_d = k_q + rsav_pkg::idx_t'(1);
        end
      end
      S_CMPRD: begin
        rd_addr_o[sel_q] = LAST;
        k_d              = '0;
        state_d          = S_CMPLP;
      end
      S_CMPLP: begin
        if (rd_data_i[sel_q] != expect_w) begin
          status_d = (k_q < rsav_pkg::idx_t'(rsav_pkg::PAD_WORDS)) ? rsav_pkg::ST_PAD
                                                                   : rsav_pkg::ST_DIGEST;
          state_d  = S_DONE;
        end else if (k_q == LAST) begin
          status_d = rsav_pkg::ST_OK;
          state_d  = S_DONE;
        end else begin
          rd_addr_o[sel_q] = LAST - (k_q + rsav_pkg::idx_t'(1));
          k_d              = k_q + rsav_pkg::idx_t'(1);
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mm_q     <= MM_FIRST;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      borrow_q <= 1'b0;
      fin_q    <= 1'b0;
      src_q    <= rsav_pkg::MEM_WP1;
      tgt_q    <= rsav_pkg::MEM_WP1;
      sel_q    <= rsav_pkg::MEM_WP1;
      status_q <= rsav_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      mm_q     <= mm_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      borrow_q <= borrow_d;
      fin_q    <= fin_d;
      src_q    <= src_d;
      tgt_q    <= tgt_d;
      sel_q    <= sel_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    q_q   <= q_d;
    acc_q <= acc_d;
    nw_q  <= nw_d;
    pa_q  <= pa_d;
    pb_q  <= pb_d;
    p_q   <= p_d;
    r_q   <= r_d;
  end

  assign res_o.valid  = (state_q == S_DONE);
  assign res_o.status = status_q;
  assign busy_o       = (state_q != S_IDLE);

endmodule

`default_nettype wire

### rtl/core/rsav_checker.sv
// ----------------------------------------------------------------------------
// rsav_checker
// Port-level checks of the verifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rsav_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          item_valid_i,
  input logic                          item_ready_i,
  input logic [rsav_pkg::ACTION_W-1:0] item_action_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [rsav_pkg::STATUS_W-1:0] res_status_i,
  input logic                          res_verified_i
);

  a_verified_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_verified_i == (res_status_i == rsav_pkg::ST_OK)))
    else $error("verified flag disagrees with status");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(res_status_i)))
    else $error("stalled result changed");

  a_verify_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && item_ready_i && (item_action_i == rsav_pkg::ACT_VERIFY))
    |=> !item_ready_i)
    else $error("request taken right after a verify");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(!item_ready_i))
    else $error("result appeared without a busy engine");

endmodule

bind rsa_e3_pkcs1_sha1_verify_core rsav_checker u_rsav_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .item_valid_i   (item_i.valid),
  .item_ready_i   (item_i.ready),
  .item_action_i  (item_i.action),
  .res_valid_i    (result_o.valid),
  .res_ready_i    (result_o.ready),
  .res_status_i   (result_o.status),
  .res_verified_i (result_o.verified)
);

`default_nettype wire
